/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ISV_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("isv assertion failed");

// checked on every edge, reset included
`define ISV_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("isv assertion failed");

`endif

/* src/isv_pkg.sv */
package isv_pkg;

    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_IMAGE_RESET = 32'd10485760;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd10;
    localparam logic [15:0] IDLE_MAX        = 16'hFFFF;
    localparam int          CRC_BITS        = 8;

    localparam logic CFG_MAX_IMAGE = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_SIZE      = 3'd1,
        ST_BUSY          = 3'd2,
        ST_OVERFLOW      = 3'd3,
        ST_SIZE_MISMATCH = 3'd4,
        ST_CRC_MISMATCH  = 3'd5,
        ST_TIMEOUT       = 3'd6,
        ST_NO_SESSION    = 3'd7
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  byte_value;
        logic [31:0] image_size;
        logic [31:0] expected_crc;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic        store_valid;
        logic [7:0]  store_byte;
        logic        session_open;
        logic        image_valid;
    } result_t;

endpackage

/* src/isv_crc8.sv */
module isv_crc8 (
    input  logic [31:0] crc,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);
    import isv_pkg::*;

    logic [31:0] acc;

    // reflected crc-32, one bit per step
    always_comb
    begin
        acc = crc ^ {24'd0, data};
        for (int i = 0; i < CRC_BITS; i++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        crc_out = acc;
    end

endmodule

/* src/isv_session.sv */
`include "assert_macros.svh"

module isv_session (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  isv_pkg::item_t  item,
    input  logic [31:0]     max_image_bytes,
    input  logic [15:0]     timeout_seconds,
    output isv_pkg::result_t res
);
    import isv_pkg::*;

    logic        active_reg, active_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] tcrc_reg, tcrc_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] idle_reg, idle_next;
    logic [31:0] crc_upd;
    logic [15:0] idle_inc;

    isv_crc8 u_crc8 (
        .crc     (crc_reg),
        .data    (item.byte_value),
        .crc_out (crc_upd)
    );

    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        active_next      = active_reg;
        size_next        = size_reg;
        tcrc_next        = tcrc_reg;
        cnt_next         = cnt_reg;
        crc_next         = crc_reg;
        idle_next        = idle_reg;
        res.status       = ST_OK;
        res.store_valid  = 1'b0;
        res.store_byte   = 8'd0;
        res.image_valid  = 1'b0;
        if (en)
        begin
            unique case (item.mode)
                MODE_START:
                begin
                    if (active_reg)
                        res.status = ST_BUSY;
                    else if (item.image_size == 32'd0 ||
                             item.image_size > max_image_bytes)
                        res.status = ST_BAD_SIZE;
                    else
                    begin
                        active_next = 1'b1;
                        size_next   = item.image_size;
                        tcrc_next   = item.expected_crc;
                        cnt_next    = 32'd0;
                        crc_next    = CRC_ALL_ONES;
                        idle_next   = 16'd0;
                    end
                end
                MODE_DATA:
                begin
                    if (!active_reg)
                        res.status = ST_NO_SESSION;
                    else if (cnt_reg >= size_reg)
                    begin
                        res.status  = ST_OVERFLOW;
                        active_next = 1'b0;
                        size_next   = 32'd0;
                        tcrc_next   = 32'd0;
                        cnt_next    = 32'd0;
                        crc_next    = 32'd0;
                        idle_next   = 16'd0;
                    end
                    else
                    begin
                        cnt_next        = cnt_reg + 32'd1;
                        crc_next        = crc_upd;
                        idle_next       = 16'd0;
                        res.store_valid = 1'b1;
                        res.store_byte  = item.byte_value;
                    end
                end
                MODE_STOP:
                begin
                    if (!active_reg)
                        res.status = ST_NO_SESSION;
                    else
                    begin
                        if (cnt_reg != size_reg)
                            res.status = ST_SIZE_MISMATCH;
                        else if ((crc_reg ^ CRC_ALL_ONES) != tcrc_reg)
                            res.status = ST_CRC_MISMATCH;
                        else
                            res.image_valid = 1'b1;
                        active_next = 1'b0;
                        size_next   = 32'd0;
                        tcrc_next   = 32'd0;
                        cnt_next    = 32'd0;
                        crc_next    = 32'd0;
                        idle_next   = 16'd0;
                    end
                end
                MODE_TICK:
                begin
                    if (active_reg)
                    begin
                        idle_next = idle_inc;
                        if (idle_inc > timeout_seconds)
                        begin
                            res.status  = ST_TIMEOUT;
                            active_next = 1'b0;
                            size_next   = 32'd0;
                            tcrc_next   = 32'd0;
                            cnt_next    = 32'd0;
                            crc_next    = 32'd0;
                            idle_next   = 16'd0;
                        end
                    end
                end
                default:
                begin
                    res.status = ST_OK;
                end
            endcase
        end
        res.session_open = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            size_reg   <= 32'd0;
            tcrc_reg   <= 32'd0;
            cnt_reg    <= 32'd0;
            crc_reg    <= 32'd0;
            idle_reg   <= 16'd0;
        end
        else
        begin
            active_reg <= active_next;
            size_reg   <= size_next;
            tcrc_reg   <= tcrc_next;
            cnt_reg    <= cnt_next;
            crc_reg    <= crc_next;
            idle_reg   <= idle_next;
        end
    end

    // closed session holds cleared counters
    `ISV_ASSERT_ALWAYS(a_closed_clear, clk,
        !active_reg |-> (cnt_reg == 32'd0 && crc_reg == 32'd0 && idle_reg == 16'd0))
    // byte count never passes the target
    `ISV_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= size_reg)
    // stored byte advances the count by one
    `ISV_ASSERT(a_store_count, clk, rst_n,
        (en && res.store_valid) |=> (cnt_reg == $past(cnt_reg) + 32'd1))

endmodule

/* src/image_session_crc_validator.sv */
// channel  direction  handshake             payload
// in       input      in_valid / in_stall    mode, byte_value, image_size, expected_crc
// out      output     out_valid / out_stall  status, store_valid, store_byte,
//                                            session_open, image_valid
// cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// one word per cycle while out_stall is low; a word moves from input to result register
// on the next edge unless the result is stalled, crc byte update and checks sit between
// reset clears session state, registers go to 10485760 bytes and 10 seconds
// a stalled result holds; the input register still loads while it is empty or its
// word moves on, so in_stall rises only when both are full and out_stall is high

`include "assert_macros.svh"

module image_session_crc_validator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  byte_value,
    input  logic [31:0] image_size,
    input  logic [31:0] expected_crc,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        store_valid,
    output logic [7:0]  store_byte,
    output logic        session_open,
    output logic        image_valid,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import isv_pkg::*;

    logic        in_vld_reg, in_vld_next;
    item_t       item_reg;
    logic        out_vld_reg, out_vld_next;
    result_t     res_reg;
    result_t     res_comb;
    logic [31:0] max_img_reg;
    logic [15:0] timeout_reg;
    logic        take;
    logic        advance;

    assign advance     = in_vld_reg & (~out_vld_reg | ~out_stall);
    assign in_stall    = in_vld_reg & ~advance;
    assign take        = in_valid & ~in_stall;
    assign in_vld_next = take | (in_vld_reg & ~advance);
    assign out_vld_next = advance | (out_vld_reg & out_stall);

    isv_session u_session (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (advance),
        .item            (item_reg),
        .max_image_bytes (max_img_reg),
        .timeout_seconds (timeout_reg),
        .res             (res_comb)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_img_reg <= MAX_IMAGE_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_IMAGE: max_img_reg <= cfg_wdata;
                CFG_TIMEOUT:   timeout_reg <= cfg_wdata[15:0];
                default:       max_img_reg <= max_img_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= '{mode: mode_t'(mode), byte_value: byte_value,
                          image_size: image_size, expected_crc: expected_crc};
        if (advance)
            res_reg <= res_comb;
    end

    assign out_valid    = out_vld_reg;
    assign status       = res_reg.status;
    assign store_valid  = res_reg.store_valid;
    assign store_byte   = res_reg.store_byte;
    assign session_open = res_reg.session_open;
    assign image_valid  = res_reg.image_valid;

    // input holds back only when both stages are full and the output stalls
    `ISV_ASSERT(a_stall_cause, clk, rst_n,
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
    // a good image closes the session with ok status
    `ISV_ASSERT(a_image_ok, clk, rst_n,
        (out_valid && image_valid) |-> (status == ST_OK && !session_open))
    // a stored word leaves the session open with ok status
    `ISV_ASSERT(a_store_ok, clk, rst_n,
        (out_valid && store_valid) |-> (status == ST_OK && session_open && !image_valid))

endmodule

/* sim/image_session_crc_validator_tb.sv */
`timescale 1ns / 100ps

module image_session_crc_validator_tb;

    import isv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        item_t   w;
        bit      typed;
        result_t r;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    mode_t       mode = MODE_START;
    logic [7:0]  byte_value = '0;
    logic [31:0] image_size = '0;
    logic [31:0] expected_crc = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        store_valid;
    logic [7:0]  store_byte;
    logic        session_open;
    logic        image_valid;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;

    // predictor copy of the block
    logic [31:0] lim_bytes = MAX_IMAGE_RESET;
    logic [15:0] lim_idle = TIMEOUT_RESET;
    logic        sess_open = 1'b0;
    logic [31:0] sess_size = '0;
    logic [31:0] sess_crc = '0;
    logic [31:0] sess_count = '0;
    logic [31:0] sess_running = '0;
    logic [15:0] sess_idle = '0;

    result_t     pending_results[$];
    result_t     want;
    row_t        plan[$];

    int unsigned errors = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned held_cycles = 0;
    int unsigned settings = 0;
    int unsigned cycle_count = 0;
    int unsigned status_seen[8];
    int unsigned max_gap = 0;
    int unsigned stall_pct = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left = 0;
    int unsigned run_left = 0;
    bit          hold_req = 1'b0;

    image_session_crc_validator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .byte_value   (byte_value),
        .image_size   (image_size),
        .expected_crc (expected_crc),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .store_valid  (store_valid),
        .store_byte   (store_byte),
        .session_open (session_open),
        .image_valid  (image_valid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] crc32_fold(logic [31:0] c, logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'h0, b};
        for (int k = 0; k < CRC_BITS; k++)
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        return x;
    endfunction

    function automatic void drop_session();
        sess_open = 1'b0;
        sess_size = '0;
        sess_crc = '0;
        sess_count = '0;
        sess_running = '0;
        sess_idle = '0;
    endfunction

    function automatic result_t validate_word(item_t w);
        result_t r;
        r = '0;
        r.status = ST_OK;
        case (w.mode)
            MODE_START:
            begin
                if (sess_open)
                    r.status = ST_BUSY;
                else if (w.image_size == 0 || w.image_size > lim_bytes)
                    r.status = ST_BAD_SIZE;
                else
                begin
                    sess_open = 1'b1;
                    sess_size = w.image_size;
                    sess_crc = w.expected_crc;
                    sess_count = '0;
                    sess_running = CRC_ALL_ONES;
                    sess_idle = '0;
                end
            end
            MODE_DATA:
            begin
                if (!sess_open)
                    r.status = ST_NO_SESSION;
                else if (sess_count >= sess_size)
                begin
                    r.status = ST_OVERFLOW;
                    drop_session();
                end
                else
                begin
                    sess_count = sess_count + 32'd1;
                    sess_running = crc32_fold(sess_running, w.byte_value);
                    sess_idle = '0;
                    r.store_valid = 1'b1;
                    r.store_byte = w.byte_value;
                end
            end
            MODE_STOP:
            begin
                if (!sess_open)
                    r.status = ST_NO_SESSION;
                else
                begin
                    if (sess_count != sess_size)
                        r.status = ST_SIZE_MISMATCH;
                    else if ((sess_running ^ CRC_ALL_ONES) != sess_crc)
                        r.status = ST_CRC_MISMATCH;
                    else
                        r.image_valid = 1'b1;
                    drop_session();
                end
            end
            default:
            begin
                if (sess_open)
                begin
                    if (sess_idle != IDLE_MAX)
                        sess_idle = sess_idle + 16'd1;
                    if (sess_idle > lim_idle)
                    begin
                        r.status = ST_TIMEOUT;
                        drop_session();
                    end
                end
            end
        endcase
        r.session_open = sess_open;
        return r;
    endfunction

    function automatic item_t mk(mode_t m, logic [7:0] b, logic [31:0] s, logic [31:0] c);
        item_t w;
        w.mode = m;
        w.byte_value = b;
        w.image_size = s;
        w.expected_crc = c;
        return w;
    endfunction

    function automatic result_t res(status_t s, logic sv, logic [7:0] sb, logic so, logic iv);
        result_t r;
        r.status = s;
        r.store_valid = sv;
        r.store_byte = sb;
        r.session_open = so;
        r.image_valid = iv;
        return r;
    endfunction

    function automatic void add_row(item_t w, bit typed, result_t r);
        row_t x;
        x.w = w;
        x.typed = typed;
        x.r = r;
        plan.push_back(x);
    endfunction

    task automatic flag(input string msg);
        errors++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input item_t w, input bit typed, input result_t typed_res);
        result_t r;
        mode <= w.mode;
        byte_value <= w.byte_value;
        image_size <= w.image_size;
        expected_crc <= w.expected_crc;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = validate_word(w);
        pending_results.push_back(typed ? typed_res : r);
        words_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if (max_gap > 0 && $urandom_range(1) == 1)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(negedge clk);
            end
        end
    endtask

    task automatic offer(input mode_t m, input logic [7:0] b, input logic [31:0] s,
                         input logic [31:0] c);
        send_word(mk(m, b, s, c), 1'b0, '0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == CFG_MAX_IMAGE)
            lim_bytes = val;
        else
            lim_idle = val[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic noise();
        repeat ($urandom_range(1, 3))
            offer(mode_t'($urandom_range(3)), 8'($urandom_range(255)), $urandom(),
                  $urandom());
    endtask

    // one image: clean, bad crc, short, overflow or idle timeout
    task automatic run_session();
        logic [7:0]  img[$];
        logic [31:0] acc;
        logic [31:0] claim;
        int unsigned cap;
        int unsigned len;
        int unsigned kind;
        int unsigned n_bytes;
        cap = (lim_bytes < 24) ? lim_bytes : 24;
        if ($urandom_range(9) == 0 && lim_bytes >= 64)
            cap = 64;
        len = $urandom_range(1, cap);
        acc = CRC_ALL_ONES;
        for (int i = 0; i < len; i++)
        begin
            img.push_back(8'($urandom_range(255)));
            acc = crc32_fold(acc, img[i]);
        end
        claim = ~acc;
        kind = $urandom_range(9);
        n_bytes = len;
        if (kind == 6)
            claim = claim ^ (32'h1 << $urandom_range(31));
        if (kind == 7)
            n_bytes = len - 1;
        if (kind == 8)
            n_bytes = len + 1;
        if (kind == 9 && lim_idle < 64)
            n_bytes = $urandom_range(0, len);
        offer(MODE_START, 8'($urandom_range(255)), len, claim);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(19) == 0)
                offer(MODE_START, 8'($urandom_range(255)), $urandom(), $urandom());
            if (lim_idle > 0 && $urandom_range(9) == 0)
                repeat ($urandom_range(1, (lim_idle < 3) ? lim_idle : 3))
                    offer(MODE_TICK, 8'($urandom_range(255)), $urandom(), $urandom());
            offer(MODE_DATA, (i < len) ? img[i] : 8'($urandom_range(255)), $urandom(),
                  $urandom());
        end
        if (kind == 9 && lim_idle < 64)
            repeat (lim_idle + 1)
                offer(MODE_TICK, 8'($urandom_range(255)), $urandom(), $urandom());
        if ((kind != 8 && kind != 9) || $urandom_range(3) == 0)
            offer(MODE_STOP, 8'($urandom_range(255)), $urandom(), $urandom());
    endtask

    task automatic run_phase(input logic [31:0] lim, input logic [15:0] tmo, input int gap,
                             input int pct, input bit hold, input int unsigned quota);
        int unsigned goal;
        settle();
        write_reg(CFG_MAX_IMAGE, lim);
        write_reg(CFG_TIMEOUT, ($urandom() & 32'hFFFF_0000) | {16'h0, tmo});
        settings++;
        max_gap = gap;
        stall_pct = pct;
        if (hold)
            hold_req = 1'b1;
        goal = words_sent + quota;
        while (words_sent < goal)
        begin
            if ($urandom_range(4) == 0)
                noise();
            else
                run_session();
        end
    endtask

    // receiver side
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (run_left > 0)
            run_left--;
        else
        begin
            run_left = $urandom_range(0, 7);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                held_cycles++;
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    flag($sformatf("result with none expected, status %0d", status));
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (status !== want.status)
                        flag($sformatf("status %0d, want %0d", status, want.status));
                    if (store_valid !== want.store_valid)
                        flag($sformatf("store_valid %0b, want %0b", store_valid,
                                       want.store_valid));
                    if (store_byte !== want.store_byte)
                        flag($sformatf("store_byte %02h, want %02h", store_byte,
                                       want.store_byte));
                    if (session_open !== want.session_open)
                        flag($sformatf("session_open %0b, want %0b", session_open,
                                       want.session_open));
                    if (image_valid !== want.image_valid)
                        flag($sformatf("image_valid %0b, want %0b", image_valid,
                                       want.image_valid));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        add_row(mk(MODE_STOP, 8'h00, 32'h0, 32'h0), 1, res(ST_NO_SESSION, 0, 8'h00, 0, 0));
        add_row(mk(MODE_DATA, 8'hFF, 32'h0, 32'h0), 1, res(ST_NO_SESSION, 0, 8'h00, 0, 0));
        add_row(mk(MODE_TICK, 8'h00, 32'h0, 32'h0), 1, res(ST_OK, 0, 8'h00, 0, 0));
        add_row(mk(MODE_START, 8'h00, 32'h0, 32'h0), 1, res(ST_BAD_SIZE, 0, 8'h00, 0, 0));
        add_row(mk(MODE_START, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                res(ST_BAD_SIZE, 0, 8'h00, 0, 0));
        add_row(mk(MODE_START, 8'h00, MAX_IMAGE_RESET + 32'd1, 32'h0), 1,
                res(ST_BAD_SIZE, 0, 8'h00, 0, 0));
        add_row(mk(MODE_START, 8'h00, MAX_IMAGE_RESET, 32'h0), 1, res(ST_OK, 0, 8'h00, 1, 0));
        add_row(mk(MODE_START, 8'h00, 32'h1, 32'h0), 1, res(ST_BUSY, 0, 8'h00, 1, 0));
        add_row(mk(MODE_TICK, 8'h00, 32'h0, 32'h0), 0, '0);
        add_row(mk(MODE_STOP, 8'h00, 32'h0, 32'h0), 1, res(ST_SIZE_MISMATCH, 0, 8'h00, 0, 0));
        // standard check string "123456789"
        add_row(mk(MODE_START, 8'h00, 32'd9, 32'hCBF4_3926), 1, res(ST_OK, 0, 8'h00, 1, 0));
        for (int i = 0; i < 9; i++)
            add_row(mk(MODE_DATA, 8'(8'h31 + i), 32'h0, 32'h0), 0, '0);
        add_row(mk(MODE_STOP, 8'h00, 32'h0, 32'h0), 1, res(ST_OK, 0, 8'h00, 0, 1));
        add_row(mk(MODE_START, 8'h00, 32'h1, 32'h0), 1, res(ST_OK, 0, 8'h00, 1, 0));
        add_row(mk(MODE_DATA, 8'h00, 32'h0, 32'h0), 0, '0);
        add_row(mk(MODE_DATA, 8'h00, 32'h0, 32'h0), 1, res(ST_OVERFLOW, 0, 8'h00, 0, 0));
        add_row(mk(MODE_START, 8'h00, 32'h1, 32'h0), 1, res(ST_OK, 0, 8'h00, 1, 0));
        add_row(mk(MODE_DATA, 8'hFF, 32'h0, 32'h0), 0, '0);
        add_row(mk(MODE_STOP, 8'h00, 32'h0, 32'h0), 1, res(ST_CRC_MISMATCH, 0, 8'h00, 0, 0));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        max_gap = 2;
        stall_pct = 25;
        foreach (plan[i])
            send_word(plan[i].w, plan[i].typed, plan[i].r);

        run_phase(MAX_IMAGE_RESET, TIMEOUT_RESET, 3, 30, 0, 120);
        run_phase(32'hFFFF_FFFF, IDLE_MAX, 0, 0, 1, 120);
        run_phase(32'd1, 16'd0, 6, 60, 0, 120);
        run_phase(32'($urandom_range(2, 100)), 16'($urandom_range(1, 6)), 2, 20, 0, 120);
        run_phase(MAX_IMAGE_RESET, TIMEOUT_RESET, 4, 45, 1, 120);
        settle();

        $display("%0d words in, %0d results checked over %0d register settings",
                 words_sent, results_checked, settings);
        $display("ok %0d, crc bad %0d, size bad %0d, overflow %0d, timeout %0d, busy %0d, %s",
                 status_seen[ST_OK], status_seen[ST_CRC_MISMATCH],
                 status_seen[ST_SIZE_MISMATCH], status_seen[ST_OVERFLOW],
                 status_seen[ST_TIMEOUT], status_seen[ST_BUSY],
                 $sformatf("input held %0d cycles", held_cycles));
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
